FILE: sv/pcs_pkg.sv
// shared constants, index tables and stage payload types of the coupling stress pipeline
`default_nettype none
package pcs_pkg;
    // fixed point fraction bits of all tensors
    localparam int FRAC_BITS = 16;
    // result width and quotient bits (one above the result for overflow)
    localparam int OW = 48;
    localparam int QB = OW + 1;
    // entries of C and the det minors, and their partial products
    localparam int CW = 66;
    localparam int PPW = 68;
    // products of two C entries and adjugate entries
    localparam int PW = 132;
    // det partial products, det, and scaled denominator
    localparam int DPW = 66;
    localparam int DTW = 100;
    localparam int DENW = DTW + FRAC_BITS;
    // denominator magnitude
    localparam int DW = 96 + FRAC_BITS;
    // numerator partials, half sums, full value and magnitude
    localparam int NPW = 70;
    localparam int NHW = 104;
    localparam int NSW = 170;
    localparam int NW = 160;
    // width of the overflow pre-check compare
    localparam int HW = (NW - QB > DW) ? NW - QB : DW;

    // C entries in the order c00 c11 c22 c01 c12 c02
    localparam int CI [6] = '{0, 1, 2, 0, 1, 0};
    localparam int CJ [6] = '{0, 1, 2, 1, 2, 2};
    // operand pairs of the twelve adjugate products, adj(i) = prod(2i) - prod(2i+1)
    localparam int PA [12] = '{1, 4, 0, 5, 0, 3, 4, 3, 3, 0, 3, 1};
    localparam int PB [12] = '{2, 4, 2, 5, 1, 3, 5, 2, 5, 4, 4, 5};

    typedef struct packed {
        logic [5:0][PW-1:0] adj;
        logic [DENW-1:0]    den;
        logic [31:0]        p;
    } t_front;

    typedef struct packed {
        logic [5:0][NW-1:0] n;
        logic [5:0]         neg;
        logic [DW-1:0]      d;
        logic               sing;
    } t_numer;

    typedef struct packed {
        logic [5:0][OW-1:0] s;
        logic               sing;
        logic               sat;
    } t_result;
endpackage
`default_nettype wire

FILE: sv/pcs_front.sv
// front stages: C = F^T F, det F, adjugate of C and the denominator
`default_nettype none
module pcs_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [8:0][31:0]      i_f,
    input  wire logic [31:0]           i_p,
    input  wire logic                  i_plane,
    output logic                       o_valid,
    output pcs_pkg::t_front            o_data
);
    logic [4:0] r_v;

    logic signed [31:0] w_f [3][3];

    logic signed [63:0] r1_pc [6][3];
    logic signed [63:0] r1_pm [6];
    logic signed [63:0] r1_pd [2];
    logic signed [31:0] r1_f0 [3];
    logic [31:0]        r1_p;
    logic               r1_plane;

    logic signed [pcs_pkg::CW-1:0] r2_c [6];
    logic signed [pcs_pkg::CW-1:0] r2_m [3];
    logic signed [pcs_pkg::CW-1:0] r2_d2;
    logic signed [31:0]            r2_f0 [3];
    logic [31:0]                   r2_p;
    logic                          r2_plane;

    logic signed [pcs_pkg::CW-33:0] w_ah [12];
    logic signed [pcs_pkg::CW-33:0] w_bh [12];
    logic signed [32:0]             w_al [12];
    logic signed [32:0]             w_bl [12];
    logic signed [pcs_pkg::CW-33:0] w_mh [3];
    logic signed [32:0]             w_ml [3];

    logic signed [pcs_pkg::PPW-1:0] r3_pp [12][4];
    logic signed [pcs_pkg::DPW-1:0] r3_dp [3][2];
    logic signed [pcs_pkg::CW-1:0]  r3_c [6];
    logic signed [pcs_pkg::CW-1:0]  r3_d2;
    logic [31:0]                    r3_p;
    logic                           r3_plane;

    logic signed [pcs_pkg::PW-1:0]  r4_prod [12];
    logic signed [pcs_pkg::DTW-1:0] r4_t [3];
    logic signed [pcs_pkg::CW-1:0]  r4_c [6];
    logic signed [pcs_pkg::CW-1:0]  r4_d2;
    logic [31:0]                    r4_p;
    logic                           r4_plane;

    pcs_pkg::t_front r5_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // plane mode drops the third row so C keeps only the 2x2 sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_f[i][j] = (i_plane && i == 2) ? '0 : $signed(i_f[i*3+j]);
            end
        end
    end

    // stage 1: all 32x32 products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 6; m++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_pc[m][k] <= w_f[k][pcs_pkg::CI[m]] * w_f[k][pcs_pkg::CJ[m]];
                end
            end
            r1_pm[0] <= w_f[1][1] * w_f[2][2];
            r1_pm[1] <= w_f[1][2] * w_f[2][1];
            r1_pm[2] <= w_f[1][0] * w_f[2][2];
            r1_pm[3] <= w_f[1][2] * w_f[2][0];
            r1_pm[4] <= w_f[1][0] * w_f[2][1];
            r1_pm[5] <= w_f[1][1] * w_f[2][0];
            r1_pd[0] <= w_f[0][0] * w_f[1][1];
            r1_pd[1] <= w_f[0][1] * w_f[1][0];
            for (int j = 0; j < 3; j++) begin
                r1_f0[j] <= w_f[0][j];
            end
            r1_p     <= i_p;
            r1_plane <= i_plane;
        end
    end

    // stage 2: C entries, det minors, plane det
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 6; m++) begin
                r2_c[m] <= pcs_pkg::CW'(r1_pc[m][0]) + pcs_pkg::CW'(r1_pc[m][1])
                         + pcs_pkg::CW'(r1_pc[m][2]);
            end
            for (int j = 0; j < 3; j++) begin
                r2_m[j] <= pcs_pkg::CW'(r1_pm[2*j]) - pcs_pkg::CW'(r1_pm[2*j+1]);
            end
            r2_d2    <= pcs_pkg::CW'(r1_pd[0]) - pcs_pkg::CW'(r1_pd[1]);
            r2_f0    <= r1_f0;
            r2_p     <= r1_p;
            r2_plane <= r1_plane;
        end
    end

    // split wide operands into a signed high part and an unsigned low word
    always_comb begin
        for (int k = 0; k < 12; k++) begin
            w_ah[k] = r2_c[pcs_pkg::PA[k]][pcs_pkg::CW-1:32];
            w_bh[k] = r2_c[pcs_pkg::PB[k]][pcs_pkg::CW-1:32];
            w_al[k] = {1'b0, r2_c[pcs_pkg::PA[k]][31:0]};
            w_bl[k] = {1'b0, r2_c[pcs_pkg::PB[k]][31:0]};
        end
        for (int j = 0; j < 3; j++) begin
            w_mh[j] = r2_m[j][pcs_pkg::CW-1:32];
            w_ml[j] = {1'b0, r2_m[j][31:0]};
        end
    end

    // stage 3: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 12; k++) begin
                r3_pp[k][0] <= w_ah[k] * w_bh[k];
                r3_pp[k][1] <= w_ah[k] * w_bl[k];
                r3_pp[k][2] <= w_al[k] * w_bh[k];
                r3_pp[k][3] <= w_al[k] * w_bl[k];
            end
            for (int j = 0; j < 3; j++) begin
                r3_dp[j][0] <= r2_f0[j] * w_mh[j];
                r3_dp[j][1] <= r2_f0[j] * w_ml[j];
            end
            r3_c     <= r2_c;
            r3_d2    <= r2_d2;
            r3_p     <= r2_p;
            r3_plane <= r2_plane;
        end
    end

    // stage 4: recombine partials
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 12; k++) begin
                r4_prod[k] <= (pcs_pkg::PW'(r3_pp[k][0]) <<< 64)
                            + ((pcs_pkg::PW'(r3_pp[k][1]) + pcs_pkg::PW'(r3_pp[k][2])) <<< 32)
                            + pcs_pkg::PW'(r3_pp[k][3]);
            end
            for (int j = 0; j < 3; j++) begin
                r4_t[j] <= (pcs_pkg::DTW'(r3_dp[j][0]) <<< 32) + pcs_pkg::DTW'(r3_dp[j][1]);
            end
            r4_c     <= r3_c;
            r4_d2    <= r3_d2;
            r4_p     <= r3_p;
            r4_plane <= r3_plane;
        end
    end

    // stage 5: adjugate and denominator, plane or full tensor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r4_plane) begin
                r5_out.adj[0] <= pcs_pkg::PW'(r4_c[1]);
                r5_out.adj[1] <= pcs_pkg::PW'(r4_c[0]);
                r5_out.adj[2] <= '0;
                r5_out.adj[3] <= -pcs_pkg::PW'(r4_c[3]);
                r5_out.adj[4] <= '0;
                r5_out.adj[5] <= '0;
                r5_out.den    <= pcs_pkg::DENW'(r4_d2);
            end else begin
                for (int i = 0; i < 6; i++) begin
                    r5_out.adj[i] <= r4_prod[2*i] - r4_prod[2*i+1];
                end
                r5_out.den <= (pcs_pkg::DENW'(r4_t[0]) - pcs_pkg::DENW'(r4_t[1])
                             + pcs_pkg::DENW'(r4_t[2])) <<< pcs_pkg::FRAC_BITS;
            end
            r5_out.p <= r4_p;
        end
    end

    assign o_valid = r_v[4];
    assign o_data  = r5_out;
endmodule
`default_nettype wire

FILE: sv/pcs_numer.sv
// numerator stages: -p * adj(C), magnitudes and quotient signs
`default_nettype none
module pcs_numer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire pcs_pkg::t_front  i_data,
    output logic                  o_valid,
    output pcs_pkg::t_numer       o_data
);
    logic [3:0] r_v;

    logic signed [32:0] w_np;
    logic signed [32:0] w_l [6][3];
    logic signed [pcs_pkg::PW-97:0] w_lt [6];
    logic signed [pcs_pkg::DENW-1:0] w_den;

    logic signed [pcs_pkg::NPW-1:0] r1_pp [6][4];
    logic [pcs_pkg::DW-1:0]         r1_d;
    logic                           r1_dneg;
    logic                           r1_sing;

    logic signed [pcs_pkg::NHW-1:0] r2_a [6];
    logic signed [pcs_pkg::NHW-1:0] r2_b [6];
    logic [pcs_pkg::DW-1:0]         r2_d;
    logic                           r2_dneg;
    logic                           r2_sing;

    logic signed [pcs_pkg::NSW-1:0] r3_num [6];
    logic [pcs_pkg::DW-1:0]         r3_d;
    logic                           r3_dneg;
    logic                           r3_sing;

    pcs_pkg::t_numer r4_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_comb begin
        w_np  = -$signed({i_data.p[31], i_data.p});
        w_den = $signed(i_data.den);
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_l[i][j] = {1'b0, i_data.adj[i][32*j +: 32]};
            end
            w_lt[i] = i_data.adj[i][pcs_pkg::PW-1:96];
        end
    end

    // stage 1: limb products and denominator magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_pp[i][j] <= w_np * w_l[i][j];
                end
                r1_pp[i][3] <= w_np * w_lt[i];
            end
            r1_dneg <= w_den[pcs_pkg::DENW-1];
            r1_d    <= pcs_pkg::DW'(w_den[pcs_pkg::DENW-1] ? -w_den : w_den);
            r1_sing <= (w_den == '0);
        end
    end

    // stage 2: pairwise limb sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                r2_a[i] <= pcs_pkg::NHW'(r1_pp[i][0]) + (pcs_pkg::NHW'(r1_pp[i][1]) <<< 32);
                r2_b[i] <= pcs_pkg::NHW'(r1_pp[i][2]) + (pcs_pkg::NHW'(r1_pp[i][3]) <<< 32);
            end
            r2_d    <= r1_d;
            r2_dneg <= r1_dneg;
            r2_sing <= r1_sing;
        end
    end

    // stage 3: full numerator
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                r3_num[i] <= pcs_pkg::NSW'(r2_a[i]) + (pcs_pkg::NSW'(r2_b[i]) <<< 64);
            end
            r3_d    <= r2_d;
            r3_dneg <= r2_dneg;
            r3_sing <= r2_sing;
        end
    end

    // stage 4: magnitude and sign of each quotient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                r4_out.neg[i] <= r3_num[i][pcs_pkg::NSW-1] ^ r3_dneg;
                r4_out.n[i]   <= pcs_pkg::NW'(r3_num[i][pcs_pkg::NSW-1] ? -r3_num[i]
                                                                       : r3_num[i]);
            end
            r4_out.d    <= r3_d;
            r4_out.sing <= r3_sing;
        end
    end

    assign o_valid = r_v[3];
    assign o_data  = r4_out;
endmodule
`default_nettype wire

FILE: sv/pcs_div.sv
// pipelined restoring divider, one quotient bit per stage, rounding and saturation
`default_nettype none
module pcs_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire pcs_pkg::t_numer  i_data,
    output logic                  o_valid,
    output pcs_pkg::t_result      o_data
);
    localparam int QB = pcs_pkg::QB;
    localparam int DW = pcs_pkg::DW;
    localparam int OW = pcs_pkg::OW;

    logic [QB+1:0] r_v;

    logic [DW-1:0] r_r    [QB+1][6];
    logic [QB-1:0] r_q    [QB+1][6];
    logic [QB-1:0] r_nl   [QB][6];
    logic [5:0]    r_big  [QB+1];
    logic [5:0]    r_neg  [QB+1];
    logic [DW-1:0] r_d    [QB+1];
    logic          r_sing [QB+1];

    logic [pcs_pkg::HW-1:0] w_h [6];

    logic [QB:0]   w_qr  [6];
    logic [QB:0]   w_lim [6];
    logic [QB:0]   w_mag [6];
    logic [5:0]    w_sat;

    pcs_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB:0], i_valid};
        end
    end

    // stage 0: quotient too large for the result width, and the first remainder
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_h[i] = pcs_pkg::HW'(i_data.n[i][pcs_pkg::NW-1:QB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                r_big[0][i] <= (w_h[i] >= pcs_pkg::HW'(i_data.d));
                r_r[0][i]   <= DW'(w_h[i]);
                r_q[0][i]   <= '0;
                r_nl[0][i]  <= i_data.n[i][QB-1:0];
            end
            r_neg[0]  <= i_data.neg;
            r_d[0]    <= i_data.d;
            r_sing[0] <= i_data.sing;
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        logic [DW:0] w_t  [6];
        logic [5:0]  w_ge;

        always_comb begin
            for (int i = 0; i < 6; i++) begin
                w_t[i]  = {r_r[s-1][i], r_nl[s-1][i][QB-1]};
                w_ge[i] = (w_t[i] >= {1'b0, r_d[s-1]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 6; i++) begin
                    r_r[s][i] <= w_ge[i] ? DW'(w_t[i] - {1'b0, r_d[s-1]}) : DW'(w_t[i]);
                    r_q[s][i] <= {r_q[s-1][i][QB-2:0], w_ge[i]};
                end
                r_big[s]  <= r_big[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_d[s]    <= r_d[s-1];
                r_sing[s] <= r_sing[s-1];
            end
        end

        if (s < QB) begin : g_nl
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int i = 0; i < 6; i++) begin
                        r_nl[s][i] <= {r_nl[s-1][i][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // round half away from zero on the magnitude, then clip
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_qr[i]  = {1'b0, r_q[QB][i]}
                     + (QB+1)'({r_r[QB][i], 1'b0} >= {1'b0, r_d[QB]});
            w_lim[i] = r_neg[QB][i] ? ((QB+1)'(1) << (OW-1))
                                    : (((QB+1)'(1) << (OW-1)) - (QB+1)'(1));
            w_sat[i] = r_big[QB][i] || (w_qr[i] > w_lim[i]);
            w_mag[i] = w_sat[i] ? w_lim[i] : w_qr[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                if (r_sing[QB]) begin
                    r_out.s[i] <= '0;
                end else begin
                    r_out.s[i] <= OW'(r_neg[QB][i] ? -w_mag[i] : w_mag[i]);
                end
            end
            r_out.sing <= r_sing[QB];
            r_out.sat  <= !r_sing[QB] && (w_sat != '0);
        end
    end

    assign o_valid = r_v[QB+1];
    assign o_data  = r_out;
endmodule
`default_nettype wire

FILE: sv/poro_coupling_stress_unit.sv
// top level of the poroelastic pressure coupling stress unit
//
// computes S = -J * p * C^-1 (as -p * adj(C) / J) from a deformation gradient F
// and a pore pressure p, all signed Q16.16, results Q32.16 in Voigt order
// input channel: i_valid / o_stall, one transfer per item (nine F entries, pressure)
// output channel: o_valid / i_stall, one transfer per result item
// config channel: i_cfg_valid / o_cfg_ready, bit 0 of i_cfg_data is plane mode;
// ready is always high, write only while the pipeline is empty
// throughput: one item per cycle while the receiver does not stall, fully pipelined
// register stages from input transfer to o_valid:
//   5 front stages (C, det, adjugate), 4 numerator stages,
//   1 overflow pre-check, 49 divider stages (one quotient bit each), 1 round/clip
// reset (synchronous, active low) empties the pipeline and clears plane mode
// when the receiver stalls a waiting result, the whole pipeline holds and
// o_stall goes high; nothing is dropped or repeated
// singular F (det zero) gives zero stress and the singular flag
`default_nettype none
module poro_coupling_stress_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input item
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_f_xx,
    input  wire logic signed [31:0] i_f_xy,
    input  wire logic signed [31:0] i_f_xz,
    input  wire logic signed [31:0] i_f_yx,
    input  wire logic signed [31:0] i_f_yy,
    input  wire logic signed [31:0] i_f_yz,
    input  wire logic signed [31:0] i_f_zx,
    input  wire logic signed [31:0] i_f_zy,
    input  wire logic signed [31:0] i_f_zz,
    input  wire logic signed [31:0] i_pressure,
    // result item
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [47:0]      o_stress_xx,
    output logic signed [47:0]      o_stress_yy,
    output logic signed [47:0]      o_stress_zz,
    output logic signed [47:0]      o_stress_shear_xy,
    output logic signed [47:0]      o_stress_shear_yz,
    output logic signed [47:0]      o_stress_shear_xz,
    output logic                    o_singular_flag,
    output logic                    o_saturated_flag,
    // configuration write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_data
);
    logic r_plane;
    logic w_en;
    logic [8:0][31:0] w_f;

    logic             w_front_valid;
    pcs_pkg::t_front  w_front;
    logic             w_numer_valid;
    pcs_pkg::t_numer  w_numer;
    logic             w_res_valid;
    pcs_pkg::t_result w_res;

    // plane mode register, writes are always taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= 1'b0;
        end else if (i_cfg_valid) begin
            r_plane <= i_cfg_data[0];
        end
    end
    assign o_cfg_ready = 1'b1;

    // every stage advances unless a finished result is held by the receiver
    assign w_en    = !(w_res_valid && i_stall);
    assign o_stall = !w_en;

    // F row by row
    assign w_f[0] = i_f_xx;
    assign w_f[1] = i_f_xy;
    assign w_f[2] = i_f_xz;
    assign w_f[3] = i_f_yx;
    assign w_f[4] = i_f_yy;
    assign w_f[5] = i_f_yz;
    assign w_f[6] = i_f_zx;
    assign w_f[7] = i_f_zy;
    assign w_f[8] = i_f_zz;

    pcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_f     (w_f),
        .i_p     (i_pressure),
        .i_plane (r_plane),
        .o_valid (w_front_valid),
        .o_data  (w_front)
    );

    pcs_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_data  (w_front),
        .o_valid (w_numer_valid),
        .o_data  (w_numer)
    );

    // last divider stage doubles as the output register
    pcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_numer_valid),
        .i_data  (w_numer),
        .o_valid (w_res_valid),
        .o_data  (w_res)
    );

    assign o_valid           = w_res_valid;
    assign o_stress_xx       = w_res.s[0];
    assign o_stress_yy       = w_res.s[1];
    assign o_stress_zz       = w_res.s[2];
    assign o_stress_shear_xy = w_res.s[3];
    assign o_stress_shear_yz = w_res.s[4];
    assign o_stress_shear_xz = w_res.s[5];
    assign o_singular_flag   = w_res.sing;
    assign o_saturated_flag  = w_res.sat;
endmodule
`default_nettype wire
